@@ hdl/priority_voice_allocator_macros.svh @@
// Assertion macros shared by the allocator's checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef PRIORITY_VOICE_ALLOCATOR_MACROS_SVH
`define PRIORITY_VOICE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, held off during reset
`define PAV_ASSERT_IMPLY(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("pav: same-cycle implication failed");

// Next-cycle implication, held off during reset
`define PAV_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("pav: next-cycle implication failed");

`endif

@@ hdl/pav_pkg.sv @@
// Package for the priority voice allocator: field widths, operation,
// status and register codes, and the packed channel entry types. No dependencies.
package pav_pkg;

  localparam int CHANNELS_DEF = 16;

  localparam int OP_W       = 3;
  localparam int ST_W       = 3;
  localparam int PRI_W      = 8;
  localparam int JOB_W      = 31;
  localparam int ADDR_W     = 32;
  localparam int BYTES_W    = 32;
  localparam int KIND_W     = 8;
  localparam int COORD_W    = 32;
  localparam int REL_W      = 4;
  localparam int CHAN_OUT_W = 4;
  localparam int VOL_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // operation codes
  localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
  localparam logic [OP_W-1:0] OP_QUERY   = 3'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP    = 3'd3;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK         = 3'd0;
  localparam logic [ST_W-1:0] ST_DISABLED   = 3'd1;
  localparam logic [ST_W-1:0] ST_ZERO_PRI   = 3'd2;
  localparam logic [ST_W-1:0] ST_NO_CHANNEL = 3'd3;
  localparam logic [ST_W-1:0] ST_MISSING    = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EFFECTS_VOL = 1'b1;

  localparam logic [VOL_W-1:0] VOL_RESET = 16'd256;

  // scheduling data, searched on every add, query and restart
  typedef struct packed {
    logic [PRI_W-1:0] prio;
    logic [JOB_W-1:0] job;
  } voice_meta_t;

  // playback record of one channel
  typedef struct packed {
    logic [ADDR_W-1:0]    address;
    logic [BYTES_W-2:0]   samples;
    logic [JOB_W-1:0]     position;
    logic [2*VOL_W-1:0]   volumes;
    logic [KIND_W:0]      kind_first;
    logic [COORD_W-1:0]   origin_x;
    logic [COORD_W-1:0]   origin_y;
    logic [COORD_W-1:0]   origin_z;
  } voice_rec_t;

endpackage

@@ hdl/pav_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pav_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/priority_voice_allocator.sv @@
// Priority voice allocator: a table of sound channels with priority stealing.
// Depends on pav_pkg and pav_ram.
//
// Use: a command word is taken at a rising edge with start high and busy low.
// Its answer appears on out_status, out_new_job_id, out_is_active and
// out_chosen_channel for exactly one cycle, marked by out_valid; the receiver
// cannot stall it. Configuration goes through cfg_we, cfg_index, cfg_wdata:
// index 0 enable, index 1 effects volume (Q8.8); write only while idle.
// Answers: stop-all, release, disabled and rejected commands answer in the
// cycle after acceptance. Add, query and restart scan the channel memories,
// one entry read per cycle through the registered read port, then take a
// closing step: busy stays high from acceptance until the answer appears, so
// a new command is only taken once the last one is through.
// The scan over the memory read port sets how often commands can be taken.
// Reset (synchronous, rst_n low): every channel free, priorities and job ids
// read as zero, job counter zero, block disabled, effects volume 1.0.
// No clearing pass is needed; per-entry valid bits stand in for it.
module priority_voice_allocator import pav_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [PRI_W-1:0]      in_priority_req,
  input  logic [JOB_W-1:0]      in_job_id,
  input  logic [ADDR_W-1:0]     in_sound_addr,
  input  logic [BYTES_W-1:0]    in_sound_bytes,
  input  logic                  in_has_new_sound,
  input  logic [KIND_W-1:0]     in_sound_kind,
  input  logic [COORD_W-1:0]    in_origin_x,
  input  logic [COORD_W-1:0]    in_origin_y,
  input  logic [COORD_W-1:0]    in_origin_z,
  input  logic [REL_W-1:0]      in_release_index,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  output logic [ST_W-1:0]       out_status,
  output logic [JOB_W-1:0]      out_new_job_id,
  output logic                  out_is_active,
  output logic [CHAN_OUT_W-1:0] out_chosen_channel
);

  localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W   = $clog2(CHANNELS + 1);
  localparam int EXT_W   = (IDX_W > CHAN_OUT_W) ? IDX_W : CHAN_OUT_W;
  localparam int REL_X_W = (IDX_W > REL_W) ? IDX_W : REL_W;
  localparam int META_W  = $bits(voice_meta_t);
  localparam int REC_W   = $bits(voice_rec_t);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(CHANNELS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      rd_cnt_r, rd_cnt_nxt;
  logic                  chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]      chk_idx_r, chk_idx_nxt;
  logic [CHANNELS-1:0]   busy_vec_r, busy_vec_nxt;
  logic [CHANNELS-1:0]   meta_vld_r, meta_vld_nxt;
  logic [JOB_W-1:0]      job_cnt_r, job_cnt_nxt;
  logic                  enable_r, enable_nxt;
  logic [VOL_W-1:0]      eff_vol_r, eff_vol_nxt;
  logic                  found1_r, found1_nxt;
  logic [IDX_W-1:0]      pick1_r, pick1_nxt;
  logic                  found2_r, found2_nxt;
  logic [IDX_W-1:0]      pick2_r, pick2_nxt;
  logic                  hit_r, hit_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]       out_status_r, out_status_nxt;
  logic [JOB_W-1:0]      out_job_r, out_job_nxt;
  logic                  out_active_r, out_active_nxt;
  logic [CHAN_OUT_W-1:0] out_chan_r, out_chan_nxt;

  // latched command word
  logic [OP_W-1:0]       op_r;
  logic [PRI_W-1:0]      pri_r;
  logic [JOB_W-1:0]      id_r;
  logic [ADDR_W-1:0]     addr_r;
  logic [BYTES_W-1:0]    bytes_r;
  logic                  new_snd_r;
  logic [KIND_W-1:0]     kind_r;
  logic [COORD_W-1:0]    ox_r, oy_r, oz_r;

  // memory ports
  logic                  meta_we, rec_we;
  logic [IDX_W-1:0]      meta_waddr, rec_waddr, rd_addr;
  voice_meta_t           meta_wdata, meta_rdata, meta_e;
  voice_rec_t            rec_wdata, rec_rdata;

  // entry check terms and add selection
  logic                  busy_e, cand1, cand2, match;
  logic [IDX_W-1:0]      pick_sel;
  logic [EXT_W-1:0]      pick_ext;
  logic [REL_X_W-1:0]    rel_ext;
  logic [JOB_W-1:0]      job_inc;

  pav_ram #(.WIDTH(META_W), .DEPTH(CHANNELS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (rd_addr),
    .rdata (meta_rdata)
  );

  pav_ram #(.WIDTH(REC_W), .DEPTH(CHANNELS)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (rd_addr),
    .rdata (rec_rdata)
  );

  assign rd_addr = rd_cnt_r[IDX_W-1:0];

  // entry returning from memory; never-written entries read as zero
  assign meta_e  = meta_vld_r[chk_idx_r] ? meta_rdata : '0;
  assign busy_e  = busy_vec_r[chk_idx_r];
  assign cand1   = (meta_e.prio < pri_r) || !busy_e;
  assign cand2   = (meta_e.prio == pri_r);
  assign match   = busy_e && (meta_e.job == id_r);

  assign pick_sel = found1_r ? pick1_r : pick2_r;
  assign pick_ext = EXT_W'(pick_sel);
  assign rel_ext  = REL_X_W'(in_release_index);
  assign job_inc  = job_cnt_r + 1'b1;

  // next-state logic
  always_comb begin
    state_nxt      = state_r;
    rd_cnt_nxt     = rd_cnt_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    busy_vec_nxt   = busy_vec_r;
    meta_vld_nxt   = meta_vld_r;
    job_cnt_nxt    = job_cnt_r;
    enable_nxt     = enable_r;
    eff_vol_nxt    = eff_vol_r;
    found1_nxt     = found1_r;
    pick1_nxt      = pick1_r;
    found2_nxt     = found2_r;
    pick2_nxt      = pick2_r;
    hit_nxt        = hit_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_job_nxt    = out_job_r;
    out_active_nxt = out_active_r;
    out_chan_nxt   = out_chan_r;
    meta_we        = 1'b0;
    meta_waddr     = pick_sel;
    meta_wdata     = '{prio: pri_r, job: job_inc};
    rec_we         = 1'b0;
    rec_waddr      = pick_sel;
    rec_wdata      = '{address:    addr_r,
                       samples:    bytes_r[BYTES_W-1:1],
                       position:   '0,
                       volumes:    {eff_vol_r, eff_vol_r},
                       kind_first: {1'b1, kind_r},
                       origin_x:   ox_r,
                       origin_y:   oy_r,
                       origin_z:   oz_r};

    // configuration writes
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE:      enable_nxt  = cfg_wdata[0];
        CFG_EFFECTS_VOL: eff_vol_nxt = cfg_wdata[VOL_W-1:0];
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          out_status_nxt = ST_OK;
          out_job_nxt    = '0;
          out_active_nxt = 1'b0;
          out_chan_nxt   = '0;
          rd_cnt_nxt     = '0;
          chk_vld_nxt    = 1'b0;
          found1_nxt     = 1'b0;
          found2_nxt     = 1'b0;
          hit_nxt        = 1'b0;
          if (!enable_r) begin
            out_status_nxt = ST_DISABLED;
            out_valid_nxt  = 1'b1;
          end else begin
            unique case (in_operation)
              OP_ADD: begin
                priority if (in_sound_addr == '0) begin
                  out_status_nxt = ST_MISSING;
                  out_valid_nxt  = 1'b1;
                end else if (in_priority_req == '0) begin
                  out_status_nxt = ST_ZERO_PRI;
                  out_valid_nxt  = 1'b1;
                end else begin
                  state_nxt = S_SCAN;
                end
              end
              OP_QUERY: state_nxt = S_SCAN;
              OP_RESTART: begin
                if (in_has_new_sound && (in_sound_addr == '0)) begin
                  out_status_nxt = ST_MISSING;
                  out_valid_nxt  = 1'b1;
                end else begin
                  state_nxt = S_SCAN;
                end
              end
              OP_STOP: begin
                busy_vec_nxt  = '0;
                out_valid_nxt = 1'b1;
              end
              OP_RELEASE: begin
                // indexes past the table are ignored
                if (int'(in_release_index) < CHANNELS) begin
                  busy_vec_nxt[rel_ext[IDX_W-1:0]] = 1'b0;
                end
                out_valid_nxt = 1'b1;
              end
              default: out_valid_nxt = 1'b1;
            endcase
          end
        end
      end

      S_SCAN: begin
        // issue the next read
        chk_vld_nxt = (rd_cnt_r != CNT_END);
        chk_idx_nxt = rd_addr;
        if (rd_cnt_r != CNT_END) begin
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end
        // check the entry that came back
        if (chk_vld_r) begin
          unique case (op_r)
            OP_ADD: begin
              if (cand1 && !found1_r) begin
                found1_nxt = 1'b1;
                pick1_nxt  = chk_idx_r;
              end
              if (cand2 && !found2_r) begin
                found2_nxt = 1'b1;
                pick2_nxt  = chk_idx_r;
              end
            end
            OP_QUERY: begin
              if (match) begin
                hit_nxt = 1'b1;
              end
            end
            OP_RESTART: begin
              // read-modify-write of the matching record
              if (match) begin
                rec_we               = 1'b1;
                rec_waddr            = chk_idx_r;
                rec_wdata            = rec_rdata;
                rec_wdata.volumes    = {eff_vol_r, eff_vol_r};
                rec_wdata.position   = '0;
                rec_wdata.kind_first = rec_rdata.kind_first | {1'b1, {KIND_W{1'b0}}};
                if (new_snd_r) begin
                  rec_wdata.address = addr_r;
                  rec_wdata.samples = bytes_r[BYTES_W-1:1];
                end
              end
            end
            default: ;
          endcase
          if (chk_idx_r == LAST_IDX) begin
            state_nxt = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        unique case (op_r)
          OP_ADD: begin
            if (found1_r || found2_r) begin
              meta_we                = 1'b1;
              rec_we                 = 1'b1;
              meta_vld_nxt[pick_sel] = 1'b1;
              busy_vec_nxt[pick_sel] = 1'b1;
              job_cnt_nxt            = job_inc;
              out_job_nxt            = job_inc;
              out_chan_nxt           = pick_ext[CHAN_OUT_W-1:0];
            end else begin
              out_status_nxt = ST_NO_CHANNEL;
            end
          end
          OP_QUERY: out_active_nxt = hit_r;
          default: ;
        endcase
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rd_cnt_r     <= '0;
      chk_vld_r    <= 1'b0;
      chk_idx_r    <= '0;
      busy_vec_r   <= '0;
      meta_vld_r   <= '0;
      job_cnt_r    <= '0;
      enable_r     <= 1'b0;
      eff_vol_r    <= VOL_RESET;
      found1_r     <= 1'b0;
      pick1_r      <= '0;
      found2_r     <= 1'b0;
      pick2_r      <= '0;
      hit_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      out_status_r <= ST_OK;
      out_job_r    <= '0;
      out_active_r <= 1'b0;
      out_chan_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      chk_vld_r    <= chk_vld_nxt;
      chk_idx_r    <= chk_idx_nxt;
      busy_vec_r   <= busy_vec_nxt;
      meta_vld_r   <= meta_vld_nxt;
      job_cnt_r    <= job_cnt_nxt;
      enable_r     <= enable_nxt;
      eff_vol_r    <= eff_vol_nxt;
      found1_r     <= found1_nxt;
      pick1_r      <= pick1_nxt;
      found2_r     <= found2_nxt;
      pick2_r      <= pick2_nxt;
      hit_r        <= hit_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      out_job_r    <= out_job_nxt;
      out_active_r <= out_active_nxt;
      out_chan_r   <= out_chan_nxt;
    end
  end

  // command word capture
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && start) begin
      op_r      <= in_operation;
      pri_r     <= in_priority_req;
      id_r      <= in_job_id;
      addr_r    <= in_sound_addr;
      bytes_r   <= in_sound_bytes;
      new_snd_r <= in_has_new_sound;
      kind_r    <= in_sound_kind;
      ox_r      <= in_origin_x;
      oy_r      <= in_origin_y;
      oz_r      <= in_origin_z;
    end
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_new_job_id     = out_job_r;
  assign out_is_active      = out_active_r;
  assign out_chosen_channel = out_chan_r;

endmodule

@@ hdl/pav_checker.sv @@
// Port-level checker for the priority voice allocator, bound to the top level.
// Depends on pav_pkg and priority_voice_allocator_macros.svh.
`include "priority_voice_allocator_macros.svh"

module pav_checker import pav_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input logic [ST_W-1:0]       out_status,
  input logic [JOB_W-1:0]      out_new_job_id,
  input logic                  out_is_active,
  input logic [CHAN_OUT_W-1:0] out_chosen_channel
);

  // answer word classes
  logic fail_word, clean_word, hit_word, plain_word;

  assign fail_word  = out_valid && (out_status != ST_OK);
  assign clean_word = (out_new_job_id == '0) && (out_chosen_channel == '0) && !out_is_active;
  assign hit_word   = out_valid && out_is_active;
  assign plain_word = (out_status == ST_OK) && (out_new_job_id == '0);

  // an accepted word either answers next cycle or keeps the block busy
  `PAV_ASSERT_NEXT(a_accept_answers, start && !busy, busy || out_valid)

  // no answer word while a command is still in flight
  `PAV_ASSERT_IMPLY(a_quiet_while_busy, busy, !out_valid)

  // a failed command carries no id, channel or query hit
  `PAV_ASSERT_IMPLY(a_fail_is_clean, fail_word, clean_word)

  // a query hit only comes with a plain ok and no new id
  `PAV_ASSERT_IMPLY(a_hit_is_query, hit_word, plain_word)

endmodule

bind priority_voice_allocator pav_checker u_pav_checker (.*);
